>>> hdl/vat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_pkg
// Shared widths, operation codes, register indexes and stage payload types
// for the vertex affine transform pipeline.
// ----------------------------------------------------------------------------
package vat_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // product and rounding widths
  localparam int PROD_RW   = COORD_W + ANGLE_W;   // coord * cos/sin
  localparam int PROD_SW   = 2 * COORD_W;         // coord * scale
  localparam int ROT_SUM_W = PROD_RW + 1;
  localparam int ROT_FRAC  = ANGLE_W - 2;         // Q2.14
  localparam int SCL_FRAC  = 16;                  // Q16.16
  localparam int WIDE_W    = PROD_SW - SCL_FRAC;

  typedef enum logic [2:0] {
    MODE_MOVE_X = 3'd0,
    MODE_MOVE_Y = 3'd1,
    MODE_MOVE_Z = 3'd2,
    MODE_ROT_X  = 3'd3,
    MODE_ROT_Y  = 3'd4,
    MODE_ROT_Z  = 3'd5,
    MODE_SCALE  = 3'd6
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_OP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COS_ANGLE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ANGLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_RATIO  = 3'd4;

  localparam logic signed [ANGLE_W-1:0] COS_RESET   = 16'sd16384;
  localparam logic signed [COORD_W-1:0] SCALE_RESET = 32'sd65536;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [PROD_RW-1:0] prod_r_t;
  typedef logic signed [PROD_SW-1:0] prod_s_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  typedef struct packed {
    mode_t  op_mode;
    angle_t cos_angle;
    angle_t sin_angle;
    coord_t shift_amount;
    coord_t scale_ratio;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } vtx_t;

  typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    prod_r_t xc;
    prod_r_t xs;
    prod_r_t yc;
    prod_r_t ys;
    prod_r_t zc;
    prod_r_t zs;
    prod_s_t xk;
    prod_s_t yk;
    prod_s_t zk;
    logic    last;
  } prod_t;

  typedef struct packed {
    wide_t x;
    wide_t y;
    wide_t z;
    logic  last;
  } wide_vtx_t;

endpackage

>>> hdl/vat_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_mult
// First pipeline stage: forms every product the transform may need
// (coordinate times cosine, sine and scale ratio) and registers them.
// ----------------------------------------------------------------------------
module vat_mult import vat_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  vtx_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output prod_t out_data
);

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt.x    = in_data.x;
    data_nxt.y    = in_data.y;
    data_nxt.z    = in_data.z;
    data_nxt.xc   = PROD_RW'(in_data.x) * PROD_RW'(cfg.cos_angle);
    data_nxt.xs   = PROD_RW'(in_data.x) * PROD_RW'(cfg.sin_angle);
    data_nxt.yc   = PROD_RW'(in_data.y) * PROD_RW'(cfg.cos_angle);
    data_nxt.ys   = PROD_RW'(in_data.y) * PROD_RW'(cfg.sin_angle);
    data_nxt.zc   = PROD_RW'(in_data.z) * PROD_RW'(cfg.cos_angle);
    data_nxt.zs   = PROD_RW'(in_data.z) * PROD_RW'(cfg.sin_angle);
    data_nxt.xk   = PROD_SW'(in_data.x) * PROD_SW'(cfg.scale_ratio);
    data_nxt.yk   = PROD_SW'(in_data.y) * PROD_SW'(cfg.scale_ratio);
    data_nxt.zk   = PROD_SW'(in_data.z) * PROD_SW'(cfg.scale_ratio);
    data_nxt.last = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/vat_comb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_comb
// Second pipeline stage: selects the operation, adds product pairs, rounds
// to Q16.16 and registers the widened, not yet saturated, coordinates.
// ----------------------------------------------------------------------------
module vat_comb import vat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_t     in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output wide_vtx_t out_data
);

  localparam logic signed [ROT_SUM_W-1:0] ROT_HALF = ROT_SUM_W'(1) << (ROT_FRAC - 1);
  localparam logic signed [PROD_SW-1:0]   SCL_HALF = PROD_SW'(1) << (SCL_FRAC - 1);

  // round half up, floor shift
  function automatic wide_t rot_round(input logic signed [ROT_SUM_W-1:0] v);
    logic signed [ROT_SUM_W-1:0] t;
    t = v + ROT_HALF;
    return WIDE_W'(t >>> ROT_FRAC);
  endfunction

  function automatic wide_t scl_round(input prod_s_t v);
    prod_s_t t;
    t = v + SCL_HALF;
    return WIDE_W'(t >>> SCL_FRAC);
  endfunction

  logic      valid_r;
  wide_vtx_t data_r;
  wide_vtx_t data_nxt;
  logic      scale_pos;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  assign scale_pos = !cfg.scale_ratio[COORD_W-1] && (cfg.scale_ratio != '0);

  always_comb begin
    data_nxt.x    = WIDE_W'(in_data.x);
    data_nxt.y    = WIDE_W'(in_data.y);
    data_nxt.z    = WIDE_W'(in_data.z);
    data_nxt.last = in_data.last;
    unique case (cfg.op_mode)
      MODE_MOVE_X: data_nxt.x = WIDE_W'(in_data.x) + WIDE_W'(cfg.shift_amount);
      MODE_MOVE_Y: data_nxt.y = WIDE_W'(in_data.y) + WIDE_W'(cfg.shift_amount);
      MODE_MOVE_Z: data_nxt.z = WIDE_W'(in_data.z) + WIDE_W'(cfg.shift_amount);
      MODE_ROT_X: begin
        data_nxt.y = rot_round(ROT_SUM_W'(in_data.yc) - ROT_SUM_W'(in_data.zs));
        data_nxt.z = rot_round(ROT_SUM_W'(in_data.ys) + ROT_SUM_W'(in_data.zc));
      end
      MODE_ROT_Y: begin
        data_nxt.x = rot_round(ROT_SUM_W'(in_data.xc) + ROT_SUM_W'(in_data.zs));
        data_nxt.z = rot_round(ROT_SUM_W'(in_data.zc) - ROT_SUM_W'(in_data.xs));
      end
      MODE_ROT_Z: begin
        data_nxt.x = rot_round(ROT_SUM_W'(in_data.xc) - ROT_SUM_W'(in_data.ys));
        data_nxt.y = rot_round(ROT_SUM_W'(in_data.xs) + ROT_SUM_W'(in_data.yc));
      end
      MODE_SCALE: begin
        if (scale_pos) begin
          data_nxt.x = scl_round(in_data.xk);
          data_nxt.y = scl_round(in_data.yk);
          data_nxt.z = scl_round(in_data.zk);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/vat_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vat_sat
// Output stage: clamps each widened coordinate to the signed coordinate
// range and holds the result beat for the downstream receiver.
// ----------------------------------------------------------------------------
module vat_sat import vat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  wide_vtx_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output vtx_t      out_data
);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic coord_t saturate(input wide_t v);
    logic [WIDE_W-COORD_W:0] top_bits;
    top_bits = v[WIDE_W-1:COORD_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      return v[COORD_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return COORD_MIN;
    end else begin
      return COORD_MAX;
    end
  endfunction

  logic valid_r;
  vtx_t data_r;
  vtx_t data_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    data_nxt.x    = saturate(in_data.x);
    data_nxt.y    = saturate(in_data.y);
    data_nxt.z    = saturate(in_data.z);
    data_nxt.last = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

>>> hdl/vertex_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_affine_transform
// Per-vertex translate, rotate or scale of Q16.16 points with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one vertex per beat; tdata holds x, y, z, tlast marks the last
//           vertex of an object.
//   out_* : one transformed vertex per beat, same packing, tlast copied.
//   cfg_* : register writes (index, data), always ready; write only while
//           no vertex is in flight.
// Throughput: 1 vertex per cycle while the output is not stalled, set by
//   the three registered stages (multiply, add/round, saturate), each with
//   its own valid bit.
// Stall: a stage holds its beat while the next one is full; bubbles close
//   up, so input is still taken while the output beat waits, until all
//   three stages are full.
// Reset: empties the pipeline and loads the register defaults (translate
//   along x by 0, cos 1.0, sin 0, scale 1.0).
// ----------------------------------------------------------------------------
module vertex_affine_transform import vat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3*COORD_W-1:0] in_tdata,   // x_coord, y_coord, z_coord
  input  logic                 in_tlast,   // last_vertex
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*COORD_W-1:0] out_tdata,  // x_out, y_out, z_out
  output logic                 out_tlast,  // last_out
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  vtx_t      in_vtx;
  prod_t     prod_data;
  wide_vtx_t wide_data;
  vtx_t      res_data;
  logic      prod_valid;
  logic      prod_ready;
  logic      wide_valid;
  logic      wide_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op_mode      <= MODE_MOVE_X;
      cfg_r.cos_angle    <= COS_RESET;
      cfg_r.sin_angle    <= '0;
      cfg_r.shift_amount <= '0;
      cfg_r.scale_ratio  <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OP_MODE:      cfg_r.op_mode      <= mode_t'(cfg_data[2:0]);
        REG_COS_ANGLE:    cfg_r.cos_angle    <= cfg_data[ANGLE_W-1:0];
        REG_SIN_ANGLE:    cfg_r.sin_angle    <= cfg_data[ANGLE_W-1:0];
        REG_SHIFT_AMOUNT: cfg_r.shift_amount <= cfg_data[COORD_W-1:0];
        REG_SCALE_RATIO:  cfg_r.scale_ratio  <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_vtx.x    = in_tdata[COORD_W-1:0];
  assign in_vtx.y    = in_tdata[2*COORD_W-1:COORD_W];
  assign in_vtx.z    = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_vtx.last = in_tlast;

  vat_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_vtx),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_data  (prod_data)
  );

  vat_comb u_comb (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_data   (prod_data),
    .out_valid (wide_valid),
    .out_ready (wide_ready),
    .out_data  (wide_data)
  );

  vat_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (wide_valid),
    .in_ready  (wide_ready),
    .in_data   (wide_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (res_data)
  );

  assign out_tdata = {res_data.z, res_data.y, res_data.x};
  assign out_tlast = res_data.last;

  a_empty_out_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output stage is empty");

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (prod_valid && wide_valid && out_tvalid && !out_tready) |-> !in_tready)
    else $error("input taken while every stage is full and stalled");

  a_mode_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == REG_OP_MODE)
      |=> (cfg_r.op_mode == mode_t'($past(cfg_data[2:0]))))
    else $error("op_mode write lost");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !prod_valid && !wide_valid))
    else $error("pipeline not empty after reset");

endmodule

>>> tb/tb_vertex_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_affine_transform
// Self-checking bench for the vertex transform pipeline: a directed table of
// register writes and vertices, then randomized register settings and vertex
// streams under varying input gaps and output stalls. Every output beat is
// compared per field against its table result or a model of the transform.
// ----------------------------------------------------------------------------
module tb_vertex_affine_transform;
  import vat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 150;
  localparam logic [2:0] MODE_PASS = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE = 3'd7;
  localparam coord_t COORD_MAX = 32'sh7fffffff;
  localparam coord_t COORD_MIN = 32'sh80000000;

  typedef struct {
    logic                 is_write;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;
    vtx_t                 stim;
    logic                 known;
    vtx_t                 want;
  } step_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [95:0]          in_tdata;   // x_coord, y_coord, z_coord
  logic                 in_tlast;   // last_vertex
  logic                 out_tvalid;
  logic                 out_tready;
  logic [95:0]          out_tdata;  // x_out, y_out, z_out
  logic                 out_tlast;  // last_out
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // model registers
  logic [2:0] cfg_mode;
  angle_t     cfg_cos;
  angle_t     cfg_sin;
  coord_t     cfg_shift;
  coord_t     cfg_scale;

  vtx_t  expected_vertices[$];
  step_t directed_steps[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  logic  rx_hold;

  vertex_affine_transform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic coord_t clamp_coord(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) return COORD_MAX;
    if (v < -64'sh80000000) return COORD_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic vtx_t transform_vertex(input vtx_t v);
    logic signed [63:0] x, y, z, c, s, k, nx, ny, nz;
    vtx_t r;
    x = $signed(v.x);
    y = $signed(v.y);
    z = $signed(v.z);
    c = $signed(cfg_cos);
    s = $signed(cfg_sin);
    k = $signed(cfg_scale);
    nx = x;
    ny = y;
    nz = z;
    case (cfg_mode)
      MODE_MOVE_X: nx = x + $signed(cfg_shift);
      MODE_MOVE_Y: ny = y + $signed(cfg_shift);
      MODE_MOVE_Z: nz = z + $signed(cfg_shift);
      MODE_ROT_X: begin
        ny = round_q14(y * c - z * s);
        nz = round_q14(y * s + z * c);
      end
      MODE_ROT_Y: begin
        nx = round_q14(x * c + z * s);
        nz = round_q14(z * c - x * s);
      end
      MODE_ROT_Z: begin
        nx = round_q14(x * c - y * s);
        ny = round_q14(x * s + y * c);
      end
      MODE_SCALE: begin
        if (k > 0) begin
          nx = (x * k + 64'sd32768) >>> 16;
          ny = (y * k + 64'sd32768) >>> 16;
          nz = (z * k + 64'sd32768) >>> 16;
        end
      end
      default: ;
    endcase
    r.x = clamp_coord(nx);
    r.y = clamp_coord(ny);
    r.z = clamp_coord(nz);
    r.last = v.last;
    return r;
  endfunction

  function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_OP_MODE:      cfg_mode = data[2:0];
      REG_COS_ANGLE:    cfg_cos = data[15:0];
      REG_SIN_ANGLE:    cfg_sin = data[15:0];
      REG_SHIFT_AMOUNT: cfg_shift = data;
      REG_SCALE_RATIO:  cfg_scale = data;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // directed table builders
  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DAT_W-1:0] data);
    step_t st;
    st = '{is_write: 1'b1, idx: idx, data: data, stim: '0, known: 1'b0, want: '0};
    directed_steps.push_back(st);
  endfunction

  function automatic void add_vertex(input coord_t x, input coord_t y, input coord_t z,
                                     input logic last);
    step_t st;
    st = '{is_write: 1'b0, idx: '0, data: '0, stim: '0, known: 1'b0, want: '0};
    st.stim = '{x: x, y: y, z: z, last: last};
    directed_steps.push_back(st);
  endfunction

  function automatic void add_result(input coord_t x, input coord_t y, input coord_t z);
    step_t st;
    st = directed_steps.pop_back();
    st.known = 1'b1;
    st.want = '{x: x, y: y, z: z, last: st.stim.last};
    directed_steps.push_back(st);
  endfunction

  function automatic coord_t random_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3: return r[0] ? COORD_MAX - coord_t'(r[7:1]) : COORD_MIN + coord_t'(r[7:1]);
      4, 5: return coord_t'({{12{r[19]}}, r[19:0]});
      default: return r;
    endcase
  endfunction

  function automatic vtx_t random_vertex();
    vtx_t v;
    v.x = random_coord();
    v.y = random_coord();
    v.z = random_coord();
    v.last = ($urandom_range(7) == 0);
    return v;
  endfunction

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    load_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_vertex(input vtx_t v, input logic known, input vtx_t want);
    in_tvalid <= 1'b1;
    in_tdata <= {v.z, v.y, v.x};
    in_tlast <= v.last;
    do @(posedge clk); while (!in_tready);
    expected_vertices.push_back(known ? want : transform_vertex(v));
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
  endtask

  task automatic random_settings(input logic [2:0] mode);
    logic [31:0] r;
    logic [15:0] a;
    r = $urandom;
    r[2:0] = mode;
    write_register(REG_OP_MODE, r);
    for (int i = 0; i < 2; i++) begin
      r = $urandom;
      case ($urandom_range(5))
        0: a = 16'sd16384;
        1: a = -16'sd16384;
        2: a = r[15:0];
        default: a = 16'($urandom_range(32768)) - 16'd16384;
      endcase
      r[15:0] = a;
      write_register(i == 0 ? REG_COS_ANGLE : REG_SIN_ANGLE, r);
    end
    case ($urandom_range(4))
      0: r = COORD_MAX;
      1: r = COORD_MIN;
      2: r = 32'($urandom_range(65536 * 4)) - 32'd131072;
      default: r = $urandom;
    endcase
    write_register(REG_SHIFT_AMOUNT, r);
    case ($urandom_range(6))
      0: r = SCALE_RESET;
      1: r = '0;
      2: r = COORD_MAX;
      3: r = {1'b1, 31'($urandom)};
      4, 5: r = $urandom_range(32'h00040000);
      default: r = $urandom;
    endcase
    write_register(REG_SCALE_RATIO, r);
    if ($urandom_range(3) == 0)
      write_register(CFG_IDX_W'($urandom_range(REG_FIRST_SPARE, REG_LAST_SPARE)), $urandom);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : out_check
    vtx_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        report_mismatch("beat with nothing pending, x", out_tdata[31:0], '0);
      end else begin
        want = expected_vertices.pop_front();
        if (out_tdata[31:0] !== want.x) report_mismatch("x_out", out_tdata[31:0], want.x);
        if (out_tdata[63:32] !== want.y) report_mismatch("y_out", out_tdata[63:32], want.y);
        if (out_tdata[95:64] !== want.z) report_mismatch("z_out", out_tdata[95:64], want.z);
        if (out_tlast !== want.last)
          report_mismatch("last_out", 32'(out_tlast), 32'(want.last));
      end
    end
  end

  initial begin
    int send_pct[4];
    int recv_pct[4];
    int epoch;
    send_pct = '{0, 59, 0, 13};
    recv_pct = '{0, 0, 59, 13};
    epoch = 0;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    rx_hold <= 1'b0;
    cfg_mode = MODE_MOVE_X;
    cfg_cos = COS_RESET;
    cfg_sin = '0;
    cfg_shift = '0;
    cfg_scale = SCALE_RESET;

    // reset defaults: translate x by zero
    add_vertex(32'h00010000, 32'hfffe0000, 32'h00030000, 1'b0);
    add_result(32'h00010000, 32'hfffe0000, 32'h00030000);
    add_vertex(COORD_MAX, COORD_MIN, '0, 1'b1);
    add_result(COORD_MAX, COORD_MIN, '0);
    add_write(REG_SHIFT_AMOUNT, COORD_MAX);
    add_vertex(COORD_MAX, 5, 6, 1'b0);
    add_result(COORD_MAX, 5, 6);
    add_vertex(COORD_MIN, 1, 2, 1'b0);
    add_write(REG_SHIFT_AMOUNT, COORD_MIN);
    add_vertex(COORD_MIN, 0, 0, 1'b1);
    add_result(COORD_MIN, 0, 0);
    add_write(REG_OP_MODE, 32'(MODE_MOVE_Y));
    add_vertex(3, COORD_MIN, 4, 1'b0);
    add_result(3, COORD_MIN, 4);
    add_vertex(0, COORD_MAX, 0, 1'b0);
    add_write(REG_OP_MODE, 32'(MODE_MOVE_Z));
    add_write(REG_SHIFT_AMOUNT, COORD_MAX);
    add_vertex(1, 2, COORD_MAX, 1'b0);
    add_result(1, 2, COORD_MAX);
    // unit cosine, zero sine: rotation is identity
    add_write(REG_OP_MODE, 32'(MODE_ROT_X));
    add_vertex(7, COORD_MIN, COORD_MAX, 1'b0);
    add_result(7, COORD_MIN, COORD_MAX);
    // quarter turn
    add_write(REG_COS_ANGLE, 32'd0);
    add_write(REG_SIN_ANGLE, 32'd16384);
    add_vertex(5, 32'h00010000, 32'h00020000, 1'b0);
    add_result(5, 32'hfffe0000, 32'h00010000);
    add_vertex(0, 0, COORD_MIN, 1'b1);
    add_result(0, COORD_MAX, 0);
    add_write(REG_OP_MODE, 32'(MODE_ROT_Y));
    add_vertex(32'h00010000, 7, 32'h00030000, 1'b0);
    add_result(32'h00030000, 7, 32'hffff0000);
    // out-of-range cosine, tiny sine, upper data bits set
    add_write(REG_OP_MODE, 32'(MODE_ROT_Z));
    add_write(REG_COS_ANGLE, 32'habcd8000);
    add_write(REG_SIN_ANGLE, 32'h00000001);
    add_vertex(32'h00002000, 32'hffffe000, COORD_MAX, 1'b0);
    add_vertex(COORD_MIN, COORD_MIN, 0, 1'b0);
    add_write(REG_OP_MODE, 32'(MODE_SCALE));
    add_vertex(COORD_MAX, COORD_MIN, 32'h00012345, 1'b0);
    add_result(COORD_MAX, COORD_MIN, 32'h00012345);
    add_write(REG_SCALE_RATIO, 32'd0);
    add_vertex(1, 2, 3, 1'b0);
    add_result(1, 2, 3);
    add_write(REG_SCALE_RATIO, COORD_MIN);
    add_vertex(COORD_MAX, COORD_MIN, 9, 1'b1);
    add_result(COORD_MAX, COORD_MIN, 9);
    add_write(REG_SCALE_RATIO, COORD_MAX);
    add_vertex(COORD_MAX, COORD_MIN, 0, 1'b0);
    add_result(COORD_MAX, COORD_MIN, 0);
    add_write(REG_SCALE_RATIO, 32'h00008000);
    add_vertex(3, 32'hfffffffd, 32'h00010001, 1'b0);
    // unused mode passes the vertex through
    add_write(REG_OP_MODE, {29'h1fffffff, MODE_PASS});
    add_vertex(COORD_MAX, COORD_MIN, 32'h00001234, 1'b1);
    add_result(COORD_MAX, COORD_MIN, 32'h00001234);
    // spare indexes must not touch anything
    add_write(REG_FIRST_SPARE, 32'h12345678);
    add_write(REG_FIRST_SPARE + CFG_IDX_W'(1), 32'hffffffff);
    add_write(REG_LAST_SPARE, 32'h00000000);
    add_vertex(1, 2, 3, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_write) begin
        drain_results();
        write_register(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_vertex(directed_steps[i].stim, directed_steps[i].known, directed_steps[i].want);
      end
    end

    for (int p = 0; p < 4; p++) begin
      drain_results();
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      repeat (4) begin
        drain_results();
        random_settings(3'(epoch));
        epoch++;
        repeat (50) send_vertex(random_vertex(), 1'b0, '0);
      end
      if (p == 1) begin
        // long output hold-off while input keeps coming, then full drain
        drain_results();
        send_idle_pct = 0;
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
        join_none
        repeat (40) send_vertex(random_vertex(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/vat_pkg.sv
hdl/vat_mult.sv
hdl/vat_comb.sv
hdl/vat_sat.sv
hdl/vertex_affine_transform.sv
tb/tb_vertex_affine_transform.sv
